// ===== rtl/core/bsi_pkg.sv =====
// ----------------------------------------------------------------------------
// bsi_pkg
// Shared types and constants for the bounded stack with bottom increment.
// ----------------------------------------------------------------------------
package bsi_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CAP_W  = 7;
  localparam int KCNT_W = 7;
  // common width for comparing fill level against the 7-bit fields
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_INC  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] push_value;
    logic [KCNT_W-1:0]        add_count;
    logic signed [DATA_W-1:0] add_amount;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     was_empty;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic push;       // write top cell, bump fill
    logic pop_empty;  // report empty pop
    logic pop_rd;     // fetch top cell and its pending add, drop fill
    logic pop_sum;    // emit result, fetch pending add of new top
    logic inc_rd;     // fetch pending add of the highest selected cell
    logic add_wr;     // write back fetched pending add plus held operand
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic can_push;
    logic inc_zero;
  } status_t;

endpackage

// ===== rtl/core/bounded_stack_with_bottom_increment_unit.sv =====
// Push, zero-cell increment and empty pop leave busy low; an increment runs ST_INC_WR.
// Pop of a held entry: the result loads in ST_POP_SUM, then ST_POP_CARRY runs if
//   a cell is left (its pending add is fetched, then written back with the carried add).
// A new item is taken only while busy is low; busy is high in every state but ST_IDLE.
// Reset (rst_n low, synchronous): stack empty, capacity 64; memories are not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// bounded_stack_with_bottom_increment_unit
// Bounded LIFO of signed 32-bit words with push, pop and bottom-k increment.
// ----------------------------------------------------------------------------
module bounded_stack_with_bottom_increment_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  bsi_pkg::in_item_t          in_item,
  output logic                       out_strobe,
  output bsi_pkg::out_item_t         out_item,
  input  logic                       cfg_we,
  input  logic [bsi_pkg::CAP_W-1:0]  cfg_wdata
);

  bsi_pkg::cmd_t    cmd;
  bsi_pkg::status_t status;

  bsi_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .op     (in_item.op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  bsi_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .status     (status),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

`ifndef SYNTH
  a_cmd_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(cmd.pop_empty || cmd.pop_sum))
    else $error("result strobe without a pop");

  a_pop_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_sum |-> $past(cmd.pop_rd))
    else $error("pop result step without a preceding fetch");

  a_busy_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop_rd || cmd.inc_rd) |=> busy)
    else $error("multi-cycle item did not hold busy");
`endif

endmodule

// ===== rtl/core/bsi_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsi_ctrl
// Sequencer: decodes the operation and steps the datapath through it.
// ----------------------------------------------------------------------------
module bsi_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       op,
  input  bsi_pkg::status_t status,
  output bsi_pkg::cmd_t    cmd,
  output logic             busy
);

  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,
    ST_POP_SUM   = 4'b0010,
    ST_POP_CARRY = 4'b0100,
    ST_INC_WR    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (op)
            bsi_pkg::OP_PUSH: begin
              cmd.push = status.can_push;
            end
            bsi_pkg::OP_POP: begin
              if (status.empty) begin
                cmd.pop_empty = 1'b1;
              end else begin
                cmd.pop_rd = 1'b1;
                state_nxt  = ST_POP_SUM;
              end
            end
            bsi_pkg::OP_INC: begin
              if (!status.inc_zero) begin
                cmd.inc_rd = 1'b1;
                state_nxt  = ST_INC_WR;
              end
            end
            default: ;
          endcase
        end
      end
      ST_POP_SUM: begin
        cmd.pop_sum = 1'b1;
        // pending add moves down only if a cell is left below
        state_nxt = status.empty ? ST_IDLE : ST_POP_CARRY;
      end
      ST_POP_CARRY: begin
        cmd.add_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_INC_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/core/bsi_dp.sv =====
// ----------------------------------------------------------------------------
// bsi_dp
// Datapath: value memory, pending-add memory, fill counter, capacity register
// and result register. An increment is stored lazily at the highest selected
// cell and folded into the cell below when that cell is popped.
// ----------------------------------------------------------------------------
module bsi_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bsi_pkg::in_item_t           in_item,
  input  bsi_pkg::cmd_t               cmd,
  input  logic                        cfg_we,
  input  logic [bsi_pkg::CAP_W-1:0]   cfg_wdata,
  output bsi_pkg::status_t            status,
  output logic                        out_strobe,
  output bsi_pkg::out_item_t          out_item
);

  localparam int DW = bsi_pkg::DATA_W;
  localparam int AW = bsi_pkg::ADDR_W;
  localparam int CW = bsi_pkg::CNT_W;
  localparam int MW = bsi_pkg::CMP_W;

  logic [DW-1:0] val_mem [bsi_pkg::DEPTH];
  logic [DW-1:0] add_mem [bsi_pkg::DEPTH];

  logic [CW-1:0]              fill_r, fill_nxt;
  logic [bsi_pkg::CAP_W-1:0]  cap_r, cap_nxt;
  logic [DW-1:0]              opnd_r, opnd_nxt;   // increment amount or carried add
  logic [AW-1:0]              waddr_r, waddr_nxt;
  logic                       out_strobe_r, out_strobe_nxt;
  bsi_pkg::out_item_t         out_item_r, out_item_nxt;
  logic [DW-1:0]              val_q, add_q;

  logic [CW-1:0] fill_dec;
  logic [AW-1:0] top_addr;
  logic [MW-1:0] fill_ext, cap_ext, cnt_ext, sel_n;
  logic [AW-1:0] sel_top;
  logic          add_re;
  logic [AW-1:0] add_raddr;
  logic          add_we;
  logic [AW-1:0] add_waddr;
  logic [DW-1:0] add_wdata;

  assign fill_dec = fill_r - CW'(1);
  assign top_addr = fill_dec[AW-1:0];
  assign fill_ext = MW'(fill_r);
  assign cap_ext  = MW'(cap_r);
  assign cnt_ext  = MW'(in_item.add_count);
  assign sel_n    = (cnt_ext < fill_ext) ? cnt_ext : fill_ext;
  assign sel_top  = AW'(sel_n - MW'(1));

  assign status.empty    = (fill_r == '0);
  assign status.can_push = (fill_ext < cap_ext) && (fill_ext < MW'(bsi_pkg::DEPTH));
  assign status.inc_zero = (sel_n == '0);

  // pending-add memory port selection
  always_comb begin
    add_re    = cmd.pop_rd || cmd.inc_rd || (cmd.pop_sum && !status.empty);
    add_raddr = cmd.inc_rd ? sel_top : top_addr;
    add_we    = cmd.push || cmd.add_wr;
    add_waddr = cmd.push ? fill_r[AW-1:0] : waddr_r;
    add_wdata = cmd.push ? '0 : (add_q + opnd_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      val_mem[fill_r[AW-1:0]] <= in_item.push_value;
    end
    if (cmd.pop_rd) begin
      val_q <= val_mem[top_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (add_we) begin
      add_mem[add_waddr] <= add_wdata;
    end
    if (add_re) begin
      add_q <= add_mem[add_raddr];
    end
  end

  always_comb begin
    fill_nxt       = fill_r;
    cap_nxt        = cap_r;
    opnd_nxt       = opnd_r;
    waddr_nxt      = waddr_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    if (cfg_we) begin
      cap_nxt = cfg_wdata;
    end
    if (cmd.push) begin
      fill_nxt = fill_r + CW'(1);
    end
    if (cmd.pop_empty) begin
      out_strobe_nxt            = 1'b1;
      out_item_nxt.popped_value = '1;
      out_item_nxt.was_empty    = 1'b1;
    end
    if (cmd.pop_rd) begin
      fill_nxt = fill_dec;
    end
    if (cmd.pop_sum) begin
      out_strobe_nxt            = 1'b1;
      out_item_nxt.popped_value = val_q + add_q;
      out_item_nxt.was_empty    = 1'b0;
      opnd_nxt                  = add_q;
      waddr_nxt                 = top_addr;
    end
    if (cmd.inc_rd) begin
      opnd_nxt  = in_item.add_amount;
      waddr_nxt = sel_top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      cap_r        <= bsi_pkg::CAP_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      cap_r        <= cap_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opnd_r     <= opnd_nxt;
    waddr_r    <= waddr_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ===== test/bounded_stack_with_bottom_increment_unit_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_bottom_increment_unit_tb
// Self-checking bench for the bounded stack: a short table of directed
// operations, then capacity phases of random push/pop/increment traffic in
// bursts. Pops are checked against a cycle-free predictor or a row's value.
// ----------------------------------------------------------------------------
module bounded_stack_with_bottom_increment_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = bsi_pkg::DATA_W;
  localparam int CW = bsi_pkg::CAP_W;
  localparam int KW = bsi_pkg::KCNT_W;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES = 7;

  typedef struct {
    bit                  cfg_row;
    logic [CW-1:0]       cap;
    bsi_pkg::in_item_t   item;
    bit                  typed;
    bsi_pkg::out_item_t  want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  bsi_pkg::in_item_t   in_item = '0;
  logic                out_strobe;
  bsi_pkg::out_item_t  out_item;
  logic                cfg_we = 1'b0;
  logic [CW-1:0]       cfg_wdata = '0;

  // expectation carried alongside a directed row
  bit                  row_typed = 1'b0;
  bsi_pkg::out_item_t  row_want = '0;

  bounded_stack_with_bottom_increment_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------- stack predictor ----------------
  logic [DW-1:0]       stack_mem [bsi_pkg::DEPTH];
  int unsigned         fill_lvl = 0;
  logic [CW-1:0]       cap_reg = bsi_pkg::CAP_RESET;
  bsi_pkg::out_item_t  pending_pops [$];

  int errors = 0;
  int n_push = 0, n_push_dropped = 0, n_pop = 0, n_pop_empty = 0;
  int n_inc = 0, n_unused = 0, n_checked = 0, max_fill = 0, n_cfg = 0;
  int cycle_cnt = 0;

  function automatic bit stack_apply(input bsi_pkg::in_item_t it,
                                     output bsi_pkg::out_item_t res);
    int unsigned eff_cap;
    int unsigned n;
    eff_cap = (cap_reg > bsi_pkg::DEPTH) ? bsi_pkg::DEPTH : cap_reg;
    res = '0;
    case (it.op)
      bsi_pkg::OP_PUSH: begin
        n_push++;
        if (fill_lvl < eff_cap) begin
          stack_mem[fill_lvl] = it.push_value;
          fill_lvl++;
          if (fill_lvl > max_fill) max_fill = fill_lvl;
        end else begin
          n_push_dropped++;
        end
        return 1'b0;
      end
      bsi_pkg::OP_POP: begin
        n_pop++;
        if (fill_lvl > 0) begin
          fill_lvl--;
          res.popped_value = stack_mem[fill_lvl];
          res.was_empty    = 1'b0;
        end else begin
          n_pop_empty++;
          res.popped_value = '1;
          res.was_empty    = 1'b1;
        end
        return 1'b1;
      end
      bsi_pkg::OP_INC: begin
        n_inc++;
        n = (it.add_count < fill_lvl) ? it.add_count : fill_lvl;
        for (int i = 0; i < n; i++) stack_mem[i] = stack_mem[i] + it.add_amount;
        return 1'b0;
      end
      default: begin
        n_unused++;
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------- monitor: check results, then track transfers ----------------
  bsi_pkg::out_item_t want_res, pred_res;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_cnt, pending_pops.size());
      $display("status: fail");
      $finish;
    end
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_pops.size() == 0) begin
        $display("%0t: unexpected result value=%h empty=%b", $time,
                 out_item.popped_value, out_item.was_empty);
        errors++;
      end else begin
        want_res = pending_pops.pop_front();
        n_checked++;
        if (out_item.popped_value !== want_res.popped_value) begin
          $display("%0t: popped_value mismatch expected=%h actual=%h", $time,
                   want_res.popped_value, out_item.popped_value);
          errors++;
        end
        if (out_item.was_empty !== want_res.was_empty) begin
          $display("%0t: was_empty mismatch expected=%b actual=%b", $time,
                   want_res.was_empty, out_item.was_empty);
          errors++;
        end
      end
    end
    if (!rst_n) begin
      fill_lvl = 0;
      cap_reg  = bsi_pkg::CAP_RESET;
    end else begin
      if (cfg_we) begin
        cap_reg = cfg_wdata;
        n_cfg++;
      end
      if (start && !busy) begin
        if (stack_apply(in_item, pred_res))
          pending_pops = {pending_pops, (row_typed ? row_want : pred_res)};
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  function automatic bsi_pkg::in_item_t mk_item(logic [1:0] op, logic [DW-1:0] pv,
                                                logic [KW-1:0] cnt, logic [DW-1:0] amt);
    bsi_pkg::in_item_t it;
    it.op         = op;
    it.push_value = pv;
    it.add_count  = cnt;
    it.add_amount = amt;
    return it;
  endfunction

  function automatic stim_row_t item_row(logic [1:0] op, logic [DW-1:0] pv,
                                         logic [KW-1:0] cnt, logic [DW-1:0] amt);
    stim_row_t r;
    r = '{default: '0};
    r.item = mk_item(op, pv, cnt, amt);
    return r;
  endfunction

  function automatic stim_row_t pop_row(logic [DW-1:0] val, logic empty);
    stim_row_t r;
    r = item_row(bsi_pkg::OP_POP, $urandom, KW'($urandom), $urandom);
    r.typed = 1'b1;
    r.want.popped_value = val;
    r.want.was_empty    = empty;
    return r;
  endfunction

  function automatic stim_row_t cap_row(logic [CW-1:0] v);
    stim_row_t r;
    r = '{default: '0};
    r.cfg_row = 1'b1;
    r.cap = v;
    return r;
  endfunction

  function automatic bsi_pkg::in_item_t random_item(bit filling);
    int unsigned r;
    logic [1:0] op;
    logic [DW-1:0] pv, amt;
    logic [KW-1:0] cnt;
    r = $urandom_range(0, 99);
    if (filling) op = (r < 78) ? bsi_pkg::OP_PUSH : (r < 88) ? bsi_pkg::OP_POP :
                      (r < 97) ? bsi_pkg::OP_INC : OP_UNUSED;
    else         op = (r < 10) ? bsi_pkg::OP_PUSH : (r < 80) ? bsi_pkg::OP_POP :
                      (r < 97) ? bsi_pkg::OP_INC : OP_UNUSED;
    case ($urandom_range(0, 9))
      0:       pv = 32'h7fff_ffff;
      1:       pv = 32'h8000_0000;
      2:       pv = '1;
      default: pv = $urandom;
    endcase
    if ($urandom_range(0, 1)) cnt = KW'($urandom_range(0, fill_lvl + 1));
    else                      cnt = KW'($urandom_range(0, 127));
    case ($urandom_range(0, 5))
      0:       amt = 32'd1;
      1:       amt = '1;
      2:       amt = $urandom_range(0, 15);
      default: amt = $urandom;
    endcase
    return mk_item(op, pv, cnt, amt);
  endfunction

  // holds start high until the block takes the item
  task automatic send_item(bsi_pkg::in_item_t it, bit typed, bsi_pkg::out_item_t want);
    start     <= 1'b1;
    in_item   <= it;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // push and increment give no result, so allow the worst-case latency after the last pop
  task automatic set_capacity(logic [CW-1:0] v);
    start <= 1'b0;
    while (pending_pops.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  int burst_left = 1;

  task automatic burst_gap();
    burst_left--;
    if (burst_left <= 0) begin
      pause($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
    end
  endtask

  // ---------------- main sequence ----------------
  stim_row_t dir_tab [$];
  int unsigned phase_caps [NUM_PHASES];
  int unsigned phase_lens [NUM_PHASES] = '{200, 60, 110, 30, 40, 80, 80};

  function automatic void add_row(stim_row_t r);
    dir_tab = {dir_tab, r};
  endfunction

  initial begin
    bsi_pkg::out_item_t no_want;
    no_want = '0;
    phase_caps = '{127, 5, 64, 0, 1, 40, $urandom_range(0, 127)};

    add_row(pop_row('1, 1'b1));                                    // pop right after reset
    add_row(item_row(bsi_pkg::OP_PUSH, 32'h7fff_ffff, 7'd0, 32'd0));
    add_row(item_row(bsi_pkg::OP_PUSH, 32'h8000_0000, 7'd127, '1));
    add_row(item_row(bsi_pkg::OP_PUSH, 32'd0, 7'd0, 32'd0));
    add_row(item_row(bsi_pkg::OP_INC, '1, 7'd0, 32'd5));            // zero cells
    add_row(item_row(bsi_pkg::OP_INC, 32'd0, 7'd127, 32'd1));       // count above fill, wraps
    add_row(item_row(OP_UNUSED, '1, 7'd127, '1));
    add_row(item_row(bsi_pkg::OP_POP, 32'd0, 7'd0, 32'd0));
    add_row(item_row(bsi_pkg::OP_INC, 32'd0, 7'd1, '1));
    add_row(item_row(bsi_pkg::OP_POP, 32'd0, 7'd0, 32'd0));
    add_row(item_row(bsi_pkg::OP_POP, '1, 7'd64, '1));
    add_row(pop_row('1, 1'b1));
    add_row(cap_row(7'd0));                                        // every push dropped
    add_row(item_row(bsi_pkg::OP_PUSH, 32'd123, 7'd0, 32'd0));
    add_row(pop_row('1, 1'b1));
    add_row(cap_row(7'd1));
    add_row(item_row(bsi_pkg::OP_PUSH, 32'h5555_5555, 7'd0, 32'd0));
    add_row(item_row(bsi_pkg::OP_PUSH, 32'haaaa_aaaa, 7'd0, 32'd0));
    add_row(pop_row(32'h5555_5555, 1'b0));
    add_row(cap_row(7'd127));                                      // saturates at depth
    add_row(item_row(bsi_pkg::OP_PUSH, '1, 7'd64, 32'd0));
    add_row(item_row(bsi_pkg::OP_INC, 32'd0, 7'd64, 32'h8000_0000));
    add_row(item_row(bsi_pkg::OP_POP, 32'd0, 7'd0, 32'd0));
    add_row(pop_row('1, 1'b1));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg_row) set_capacity(dir_tab[i].cap);
      else begin
        send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
        if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 3));
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_capacity(CW'(phase_caps[p]));
      for (int k = 0; k < phase_lens[p]; k++) begin
        send_item(random_item(k < phase_lens[p] * 7 / 10), 1'b0, no_want);
        burst_gap();
      end
    end

    start <= 1'b0;
    while (pending_pops.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("covered %0d pushes (%0d dropped at capacity), %0d pops (%0d empty),",
             n_push, n_push_dropped, n_pop, n_pop_empty);
    $display("%0d increments, %0d unused codes, %0d capacity writes, peak fill %0d, %0d checked",
             n_inc, n_unused, n_cfg, max_fill, n_checked);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
